>>> hdl/roa_pkg.sv
package roa_pkg;

  typedef enum logic [2:0] {
    MODE_ADD   = 3'd0,
    MODE_SUB   = 3'd1,
    MODE_DIV   = 3'd2,
    MODE_PLUS  = 3'd3,
    MODE_MINUS = 3'd4,
    MODE_SOLVX = 3'd5,
    MODE_SOLVY = 3'd6,
    MODE_NONE  = 3'd7
  } mode_t;

  typedef struct packed {
    logic [2:0]   mode;
    logic [31:0]  a_num;
    logic [31:0]  a_den;
    logic [31:0]  a_off;
    logic [31:0]  b_num;
    logic [31:0]  b_den;
    logic [31:0]  b_off;
    logic [31:0]  operand;
  } in_item_t;

  typedef struct packed {
    logic [31:0]  res_num;
    logic [31:0]  res_den;
    logic [31:0]  res_off;
    logic [31:0]  solved;
    logic         div_zero;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL1,
    ST_MUL2,
    ST_GCD_CHK,
    ST_GCD_DIV,
    ST_GCD_WAIT,
    ST_RED_NUM,
    ST_RED_NUM_W,
    ST_RED_DEN,
    ST_RED_DEN_W,
    ST_QDIV,
    ST_QDIV_W,
    ST_DONE
  } state_t;

  // Datapath commands
  typedef struct packed {
    logic load;        // capture input item
    logic mul1;        // first product step
    logic mul2;        // second product step
    logic gcd_start;   // start m % n
    logic gcd_step;    // rotate m,n after remainder
    logic rn_start;    // |num| / g
    logic rn_take;
    logic rd_start;    // |den| / g
    logic rd_take;
    logic q_start;     // signed quotient for divide and solve
    logic q_take;
    logic finish;      // emit result
  } dp_cmd_t;

  typedef struct packed {
    logic       two_step;   // add/sub needs gcd
    logic       need_div;   // divide / solve
    logic       zero_div;   // divisor zero
    logic       n_zero;     // gcd loop done
    logic       div_done;
  } dp_sts_t;

endpackage

>>> hdl/roa_divider.sv
module roa_divider (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [31:0] quot,
  output logic [31:0] rem
);

  logic [31:0] q_r, q_nxt;
  logic [31:0] r_r, r_nxt;
  logic [31:0] d_r, d_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [32:0] trial;
  logic [32:0] shifted;

  // One quotient bit per cycle, restoring
  always_comb begin
    q_nxt = q_r;
    r_nxt = r_r;
    d_nxt = d_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    shifted = {r_r, q_r[31]};
    trial = shifted - {1'b0, d_r};
    if (start) begin
      q_nxt = dividend;
      r_nxt = '0;
      d_nxt = divisor;
      cnt_nxt = 6'd32;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[32]) begin
        r_nxt = trial[31:0];
        q_nxt = {q_r[30:0], 1'b1};
      end else begin
        r_nxt = shifted[31:0];
        q_nxt = {q_r[30:0], 1'b0};
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r <= cnt_nxt;
    end
    q_r <= q_nxt;
    r_r <= r_nxt;
    d_r <= d_nxt;
  end

  assign done = done_r;
  assign quot = q_r;
  assign rem = r_r;

endmodule

>>> hdl/roa_datapath.sv
module roa_datapath (
  input  logic                clk,
  input  roa_pkg::in_item_t   in_item,
  input  roa_pkg::dp_cmd_t    cmd,
  output roa_pkg::dp_sts_t    sts,
  output roa_pkg::out_item_t  out_item
);

  roa_pkg::in_item_t it_r;
  logic [31:0] p_r, q_r, num_r, den_r;
  logic [31:0] m_r, n_r;
  logic [31:0] rn_r, rd_r, qt_r;
  logic [31:0] dvd_sel, dvs_sel;
  logic [31:0] dvd_mag, dvs_mag, num_c;
  logic        q_neg_r, q_neg;
  logic        dv_start, dv_done;
  logic [31:0] dv_quot, dv_rem;
  logic [31:0] mag_den, mag_num;
  logic [31:0] nv, nd;
  logic [31:0] a_x, b_x;
  roa_pkg::out_item_t res;

  function automatic logic [31:0] mag(input logic [31:0] v);
    mag = v[31] ? (32'd0 - v) : v;
  endfunction

  assign dv_start = cmd.gcd_start | cmd.rn_start | cmd.rd_start | cmd.q_start;

  // Dividend/divisor for signed-quotient modes
  always_comb begin
    a_x = '0;
    b_x = '0;
    unique case (roa_pkg::mode_t'(it_r.mode))
      roa_pkg::MODE_DIV: begin
        a_x = it_r.a_off;
        b_x = it_r.operand;
      end
      roa_pkg::MODE_SOLVX: begin
        a_x = p_r;
        b_x = it_r.a_den;
      end
      roa_pkg::MODE_SOLVY: begin
        a_x = p_r;
        b_x = it_r.a_num;
      end
      default: begin
        a_x = '0;
        b_x = '0;
      end
    endcase
    q_neg = a_x[31] ^ b_x[31];
    dvd_mag = mag(a_x);
    dvs_mag = mag(b_x);
  end

  // m_r holds the gcd once the Euclid loop has ended
  always_comb begin
    dvd_sel = dvd_mag;
    dvs_sel = dvs_mag;
    if (cmd.gcd_start) begin
      dvd_sel = m_r;
      dvs_sel = n_r;
    end else if (cmd.rn_start) begin
      dvd_sel = mag_num;
      dvs_sel = m_r;
    end else if (cmd.rd_start) begin
      dvd_sel = mag_den;
      dvs_sel = m_r;
    end
  end

  roa_divider u_div (
    .clk      (clk),
    .rst_n    (1'b1),
    .start    (dv_start),
    .dividend (dvd_sel),
    .divisor  (dvs_sel),
    .done     (dv_done),
    .quot     (dv_quot),
    .rem      (dv_rem)
  );

  assign num_c = (it_r.mode == roa_pkg::MODE_ADD) ? (p_r + q_r) : (p_r - q_r);
  assign mag_den = mag(den_r);
  assign mag_num = mag(num_r);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      it_r <= in_item;
    end
    if (cmd.mul1) begin
      unique case (roa_pkg::mode_t'(it_r.mode))
        roa_pkg::MODE_SOLVX: p_r <= it_r.a_num * it_r.operand;
        roa_pkg::MODE_SOLVY: p_r <= it_r.operand - it_r.a_off;
        default:             p_r <= it_r.a_num * it_r.b_den;
      endcase
      q_r <= it_r.a_den * it_r.b_num;
      den_r <= it_r.a_den * it_r.b_den;
    end
    if (cmd.mul2) begin
      if (it_r.mode == roa_pkg::MODE_SOLVY) begin
        p_r <= p_r * it_r.a_den;
      end
      num_r <= num_c;
      // order so m >= n
      if (mag_den < mag(num_c)) begin
        m_r <= mag(num_c);
        n_r <= mag_den;
      end else begin
        m_r <= mag_den;
        n_r <= mag(num_c);
      end
    end
    if (cmd.gcd_step) begin
      m_r <= n_r;
      n_r <= dv_rem;
    end
    if (cmd.rn_take) begin
      rn_r <= num_r[31] ? (32'd0 - dv_quot) : dv_quot;
    end
    if (cmd.rd_take) begin
      rd_r <= den_r[31] ? (32'd0 - dv_quot) : dv_quot;
    end
    if (cmd.q_start) begin
      q_neg_r <= q_neg;
    end
    if (cmd.q_take) begin
      qt_r <= q_neg_r ? (32'd0 - dv_quot) : dv_quot;
    end
  end

  assign nv = it_r.a_off + it_r.b_off;
  assign nd = it_r.a_off - it_r.b_off;

  always_comb begin
    res = '0;
    unique case (roa_pkg::mode_t'(it_r.mode))
      roa_pkg::MODE_ADD, roa_pkg::MODE_SUB: begin
        if (m_r == 32'd0) begin
          res.div_zero = 1'b1;
        end else begin
          res.res_num = rn_r;
          res.res_den = rd_r;
          res.res_off = (it_r.mode == roa_pkg::MODE_ADD) ? nv : nd;
        end
      end
      roa_pkg::MODE_DIV: begin
        if (it_r.operand == 32'd0) begin
          res.div_zero = 1'b1;
        end else begin
          res.res_num = it_r.a_num;
          res.res_den = it_r.a_den * it_r.operand;
          res.res_off = qt_r;
        end
      end
      roa_pkg::MODE_PLUS: begin
        res.res_num = it_r.a_num;
        res.res_den = it_r.a_den;
        res.res_off = it_r.a_off + it_r.operand;
      end
      roa_pkg::MODE_MINUS: begin
        res.res_num = it_r.a_num;
        res.res_den = it_r.a_den;
        res.res_off = it_r.a_off - it_r.operand;
      end
      roa_pkg::MODE_SOLVX: begin
        if (it_r.a_den == 32'd0) res.div_zero = 1'b1;
        else res.solved = qt_r + it_r.a_off;
      end
      roa_pkg::MODE_SOLVY: begin
        if (it_r.a_num == 32'd0) res.div_zero = 1'b1;
        else res.solved = qt_r;
      end
      default: res = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_item <= res;
    end
  end

  assign sts.two_step = (it_r.mode == roa_pkg::MODE_ADD) || (it_r.mode == roa_pkg::MODE_SUB);
  assign sts.need_div = (it_r.mode == roa_pkg::MODE_DIV) || (it_r.mode == roa_pkg::MODE_SOLVX)
                     || (it_r.mode == roa_pkg::MODE_SOLVY);
  assign sts.zero_div = (dvs_mag == 32'd0);
  assign sts.n_zero = (n_r == 32'd0);
  assign sts.div_done = dv_done;

endmodule

>>> hdl/roa_ctrl.sv
module roa_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  roa_pkg::dp_sts_t  sts,
  output roa_pkg::dp_cmd_t  cmd,
  output logic              busy,
  output logic              out_valid
);

  roa_pkg::state_t st_r, st_nxt;
  logic            ov_r;

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      roa_pkg::ST_IDLE:      if (start) st_nxt = roa_pkg::ST_MUL1;
      roa_pkg::ST_MUL1:      st_nxt = roa_pkg::ST_MUL2;
      roa_pkg::ST_MUL2: begin
        if (sts.two_step) st_nxt = roa_pkg::ST_GCD_CHK;
        else if (sts.need_div && !sts.zero_div) st_nxt = roa_pkg::ST_QDIV;
        else st_nxt = roa_pkg::ST_DONE;
      end
      roa_pkg::ST_GCD_CHK:   st_nxt = sts.n_zero ? roa_pkg::ST_RED_NUM : roa_pkg::ST_GCD_DIV;
      roa_pkg::ST_GCD_DIV:   st_nxt = roa_pkg::ST_GCD_WAIT;
      roa_pkg::ST_GCD_WAIT:  if (sts.div_done) st_nxt = roa_pkg::ST_GCD_CHK;
      roa_pkg::ST_RED_NUM:   st_nxt = roa_pkg::ST_RED_NUM_W;
      roa_pkg::ST_RED_NUM_W: if (sts.div_done) st_nxt = roa_pkg::ST_RED_DEN;
      roa_pkg::ST_RED_DEN:   st_nxt = roa_pkg::ST_RED_DEN_W;
      roa_pkg::ST_RED_DEN_W: if (sts.div_done) st_nxt = roa_pkg::ST_DONE;
      roa_pkg::ST_QDIV:      st_nxt = roa_pkg::ST_QDIV_W;
      roa_pkg::ST_QDIV_W:    if (sts.div_done) st_nxt = roa_pkg::ST_DONE;
      roa_pkg::ST_DONE:      st_nxt = roa_pkg::ST_IDLE;
      default:               st_nxt = roa_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (st_r)
      roa_pkg::ST_IDLE:      cmd.load = start;
      roa_pkg::ST_MUL1:      cmd.mul1 = 1'b1;
      roa_pkg::ST_MUL2:      cmd.mul2 = 1'b1;
      roa_pkg::ST_GCD_DIV:   cmd.gcd_start = 1'b1;
      roa_pkg::ST_GCD_WAIT:  cmd.gcd_step = sts.div_done;
      roa_pkg::ST_RED_NUM:   cmd.rn_start = 1'b1;
      roa_pkg::ST_RED_NUM_W: cmd.rn_take = sts.div_done;
      roa_pkg::ST_RED_DEN:   cmd.rd_start = 1'b1;
      roa_pkg::ST_RED_DEN_W: cmd.rd_take = sts.div_done;
      roa_pkg::ST_QDIV:      cmd.q_start = 1'b1;
      roa_pkg::ST_QDIV_W:    cmd.q_take = sts.div_done;
      roa_pkg::ST_DONE:      cmd.finish = 1'b1;
      default:               cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= roa_pkg::ST_IDLE;
      ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      ov_r <= (st_r == roa_pkg::ST_DONE);
    end
  end

  assign busy = (st_r != roa_pkg::ST_IDLE);
  assign out_valid = ov_r;

endmodule

>>> hdl/rational_offset_arithmetic.sv
// Path: plus/minus value and zero divide/solve divisors pass MUL1, MUL2, then DONE;
//   divide/solve add a quotient pass, add/subtract the Euclid loop and both reductions.
// Throughput: one item at a time; a one-bit-per-cycle divider sets the rate and is
//   shared by every Euclid remainder, both reductions and the quotient.
// Reset: synchronous active-low rst_n returns to idle; no result pending.
// out_valid is a one-cycle strobe; the receiver cannot stall.
module rational_offset_arithmetic (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  roa_pkg::in_item_t   in_item,
  output logic                out_valid,
  output roa_pkg::out_item_t  out_item
);

  roa_pkg::dp_cmd_t cmd;
  roa_pkg::dp_sts_t sts;

  roa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .sts       (sts),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  roa_datapath u_dp (
    .clk      (clk),
    .in_item  (in_item),
    .cmd      (cmd),
    .sts      (sts),
    .out_item (out_item)
  );

endmodule

>>> bench/rational_offset_arithmetic_test.sv
`timescale 1ns / 1ps

module rational_offset_arithmetic_test;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  roa_pkg::in_item_t  in_item = '0;
  logic               out_valid;
  roa_pkg::out_item_t out_item;

  roa_pkg::out_item_t pending_results[$];
  int                 fail_count = 0;

  typedef struct {
    roa_pkg::in_item_t  beat;
    bit                 typed;
    roa_pkg::out_item_t want;
  } stim_row_t;

  rational_offset_arithmetic dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_item(in_item), .out_valid(out_valid), .out_item(out_item)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #20000000;
    $display("rational_offset_arithmetic_test: FAIL");
    $finish;
  end

  function automatic logic [31:0] magnitude(logic [31:0] v);
    return v[31] ? 32'd0 - v : v;
  endfunction

  function automatic logic [31:0] trunc_div(logic [31:0] a, logic [31:0] b);
    logic [31:0] q;
    q = magnitude(a) / magnitude(b);
    return (a[31] ^ b[31]) ? 32'd0 - q : q;
  endfunction

  function automatic logic [31:0] euclid_gcd(logic [31:0] x, logic [31:0] y);
    logic [31:0] m, n, t;
    m = magnitude(x);
    n = magnitude(y);
    if (m < n) begin
      t = m; m = n; n = t;
    end
    while (n != 0) begin
      t = m % n; m = n; n = t;
    end
    return m;
  endfunction

  function automatic roa_pkg::out_item_t compute_attachment(roa_pkg::in_item_t it);
    roa_pkg::out_item_t r;
    logic [31:0]        num, den, g, q;
    r = '0;
    case (roa_pkg::mode_t'(it.mode))
      roa_pkg::MODE_ADD, roa_pkg::MODE_SUB: begin
        num = (it.mode == roa_pkg::MODE_ADD) ? it.a_num * it.b_den + it.a_den * it.b_num
                                             : it.a_num * it.b_den - it.a_den * it.b_num;
        den = it.a_den * it.b_den;
        g = euclid_gcd(den, num);
        if (g == 0) r.div_zero = 1'b1;
        else begin
          q = magnitude(num) / g;
          r.res_num = num[31] ? 32'd0 - q : q;
          q = magnitude(den) / g;
          r.res_den = den[31] ? 32'd0 - q : q;
          r.res_off = (it.mode == roa_pkg::MODE_ADD) ? it.a_off + it.b_off
                                                     : it.a_off - it.b_off;
        end
      end
      roa_pkg::MODE_DIV: begin
        if (it.operand == 0) r.div_zero = 1'b1;
        else begin
          r.res_num = it.a_num;
          r.res_den = it.a_den * it.operand;
          r.res_off = trunc_div(it.a_off, it.operand);
        end
      end
      roa_pkg::MODE_PLUS: begin
        r.res_num = it.a_num; r.res_den = it.a_den; r.res_off = it.a_off + it.operand;
      end
      roa_pkg::MODE_MINUS: begin
        r.res_num = it.a_num; r.res_den = it.a_den; r.res_off = it.a_off - it.operand;
      end
      roa_pkg::MODE_SOLVX: begin
        if (it.a_den == 0) r.div_zero = 1'b1;
        else r.solved = trunc_div(it.a_num * it.operand, it.a_den) + it.a_off;
      end
      roa_pkg::MODE_SOLVY: begin
        if (it.a_num == 0) r.div_zero = 1'b1;
        else r.solved = trunc_div((it.operand - it.a_off) * it.a_den, it.a_num);
      end
      default: ;
    endcase
    return r;
  endfunction

  // sample results at the rising edge
  always @(posedge clk) begin
    roa_pkg::out_item_t w;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        $error("result beat with nothing expected");
        fail_count++;
      end else begin
        w = pending_results.pop_front();
        if (out_item.res_num !== w.res_num) begin
          $error("res_num: expected %h actual %h", w.res_num, out_item.res_num);
          fail_count++;
        end
        if (out_item.res_den !== w.res_den) begin
          $error("res_den: expected %h actual %h", w.res_den, out_item.res_den);
          fail_count++;
        end
        if (out_item.res_off !== w.res_off) begin
          $error("res_off: expected %h actual %h", w.res_off, out_item.res_off);
          fail_count++;
        end
        if (out_item.solved !== w.solved) begin
          $error("solved: expected %h actual %h", w.solved, out_item.solved);
          fail_count++;
        end
        if (out_item.div_zero !== w.div_zero) begin
          $error("div_zero: expected %b actual %b", w.div_zero, out_item.div_zero);
          fail_count++;
        end
      end
    end
  end

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'hffff_ffff;
      3: return 32'd0;
      4, 5: return $urandom_range(0, 40) - 20;
      6: return $urandom_range(0, 2000) - 1000;
      default: return $urandom;
    endcase
  endfunction

  // enter and leave at a falling edge; start stays high when the next beat follows at once
  task automatic send_beat(roa_pkg::in_item_t it);
    int gap;
    gap = $urandom_range(0, 6);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_item <= it;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    pending_results.push_back(compute_attachment(it));
    @(negedge clk);
  endtask

  function automatic roa_pkg::in_item_t make_item(logic [2:0] m, logic [31:0] an,
      logic [31:0] ad, logic [31:0] ao, logic [31:0] bn, logic [31:0] bd, logic [31:0] bo,
      logic [31:0] v);
    roa_pkg::in_item_t it;
    it.mode = m; it.a_num = an; it.a_den = ad; it.a_off = ao;
    it.b_num = bn; it.b_den = bd; it.b_off = bo; it.operand = v;
    return it;
  endfunction

  function automatic roa_pkg::out_item_t make_res(logic [31:0] n, logic [31:0] d,
      logic [31:0] o, logic [31:0] s, logic z);
    roa_pkg::out_item_t r;
    r.res_num = n; r.res_den = d; r.res_off = o; r.solved = s; r.div_zero = z;
    return r;
  endfunction

  initial begin
    stim_row_t         rows[$];
    stim_row_t         row;
    roa_pkg::in_item_t it;
    int                waited;
    localparam logic [31:0] MIN = 32'h8000_0000;
    localparam logic [31:0] MAX = 32'h7fff_ffff;

    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // typed rows: zero divisions, undefined mode, trivial plus/minus, MIN divided by -1
    rows.push_back('{make_item(roa_pkg::MODE_ADD, 0, 0, 5, 0, 7, 9, 0), 1'b1,
                     make_res(0, 0, 0, 0, 1'b1)});
    rows.push_back('{make_item(roa_pkg::MODE_SUB, 3, 0, 5, 0, 0, 9, 0), 1'b1,
                     make_res(0, 0, 0, 0, 1'b1)});
    rows.push_back('{make_item(roa_pkg::MODE_DIV, 1, 2, 3, 0, 0, 0, 0), 1'b1,
                     make_res(0, 0, 0, 0, 1'b1)});
    rows.push_back('{make_item(roa_pkg::MODE_SOLVX, 4, 0, 1, 0, 0, 0, 3), 1'b1,
                     make_res(0, 0, 0, 0, 1'b1)});
    rows.push_back('{make_item(roa_pkg::MODE_SOLVY, 0, 4, 1, 0, 0, 0, 3), 1'b1,
                     make_res(0, 0, 0, 0, 1'b1)});
    rows.push_back('{make_item(roa_pkg::MODE_NONE, MAX, MIN, MAX, MIN, MAX, MIN, MAX), 1'b1,
                     make_res(0, 0, 0, 0, 1'b0)});
    rows.push_back('{make_item(roa_pkg::MODE_PLUS, MIN, MAX, MAX, 0, 0, 0, 1), 1'b1,
                     make_res(MIN, MAX, MIN, 0, 1'b0)});
    rows.push_back('{make_item(roa_pkg::MODE_MINUS, MAX, MIN, MIN, 0, 0, 0, 1), 1'b1,
                     make_res(MAX, MIN, MAX, 0, 1'b0)});
    rows.push_back('{make_item(roa_pkg::MODE_DIV, 1, 1, MIN, 0, 0, 0, 32'hffff_ffff), 1'b1,
                     make_res(1, 32'hffff_ffff, MIN, 0, 1'b0)});
    // predicted rows: most negative magnitude, sign handling, wraps
    rows.push_back('{make_item(roa_pkg::MODE_ADD, 1, 2, 1, 1, 3, 2, 0), 1'b0, '0});
    rows.push_back('{make_item(roa_pkg::MODE_SUB, 1, 2, 1, 1, 2, 2, 0), 1'b0, '0});
    rows.push_back('{make_item(roa_pkg::MODE_ADD, MIN, 1, MAX, 0, 1, 1, 0), 1'b0, '0});
    rows.push_back('{make_item(roa_pkg::MODE_SUB, -6, 4, MIN, 3, -8, 1, 0), 1'b0, '0});
    rows.push_back('{make_item(roa_pkg::MODE_ADD, MAX, MAX, MAX, MAX, MAX, MAX, 0), 1'b0,
                     '0});
    rows.push_back('{make_item(roa_pkg::MODE_SUB, MIN, MIN, MIN, MIN, MIN, MIN, 0), 1'b0,
                     '0});
    rows.push_back('{make_item(roa_pkg::MODE_ADD, 32'hffff_ffff, 32'hffff_ffff, 0,
                     32'hffff_ffff, 32'hffff_ffff, 0, 0), 1'b0, '0});
    rows.push_back('{make_item(roa_pkg::MODE_DIV, 7, MAX, -7, 0, 0, 0, 2), 1'b0, '0});
    rows.push_back('{make_item(roa_pkg::MODE_SOLVX, MAX, -3, MIN, 0, 0, 0, MAX), 1'b0, '0});
    rows.push_back('{make_item(roa_pkg::MODE_SOLVX, MIN, 32'hffff_ffff, 0, 0, 0, 0, 1), 1'b0,
                     '0});
    rows.push_back('{make_item(roa_pkg::MODE_SOLVY, 32'hffff_ffff, 1, 0, 0, 0, 0, MIN), 1'b0,
                     '0});
    rows.push_back('{make_item(roa_pkg::MODE_SOLVY, 3, MAX, MIN, 0, 0, 0, MAX), 1'b0, '0});

    foreach (rows[i]) begin
      row = rows[i];
      send_beat(row.beat);
      if (row.typed) pending_results[$] = row.want;
    end

    for (int k = 0; k < 900; k++) begin
      it.mode = 3'($urandom_range(0, 7));
      it.a_num = pick_word(); it.a_den = pick_word(); it.a_off = pick_word();
      it.b_num = pick_word(); it.b_den = pick_word(); it.b_off = pick_word();
      it.operand = pick_word();
      send_beat(it);
      // hold off until the block has drained
      if (k == 450) begin
        start <= 1'b0;
        while (pending_results.size() != 0) @(negedge clk);
      end
    end

    start <= 1'b0;
    waited = 0;
    while (pending_results.size() != 0 && waited < 100000) begin
      @(negedge clk);
      waited++;
    end
    repeat (400) @(negedge clk);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("rational_offset_arithmetic_test: PASS");
    end else begin
      $display("rational_offset_arithmetic_test: FAIL");
    end
    $finish;
  end
endmodule
